### rtl/core/wms_pkg.sv
// ----------------------------------------------------------------------------
// wms_pkg: shared types and constants for the winnowing minimum selector
// Holds the field widths, the controller state type and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package wms_pkg;

    localparam int HASH_W     = 64;
    localparam int WIN_SIZE_W = 7;

    localparam logic [WIN_SIZE_W-1:0] WIN_SIZE_RESET = 7'd4;
    localparam logic [HASH_W-1:0]     HASH_ONES      = {HASH_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } wms_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;      // take the input item this cycle
        logic take_min;    // new hash becomes the held minimum
        logic load_hash;   // load output register from the input hash
        logic scan_issue;  // issue one window read of the rescan
        logic load_best;   // load output from the scan result, commit minimum
    } wms_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_rescan; // the held minimum's slot gets overwritten
        logic win_one;     // window of one entry, nothing to scan
        logic hash_less;   // new hash strictly below the held minimum
        logic scan_last;   // this read is the last of the rescan
    } wms_sts_t;

endpackage

### rtl/core/wms_ram.sv
// ----------------------------------------------------------------------------
// wms_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module wms_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/wms_ctrl.sv
// ----------------------------------------------------------------------------
// wms_ctrl: sequencing controller of the winnowing minimum selector
// Accepts items, runs the window rescan and hands results to the output.
// ----------------------------------------------------------------------------
module wms_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  wms_pkg::wms_sts_t sts,
    output wms_pkg::wms_cmd_t cmd
);

    wms_pkg::wms_state_t state_reg, state_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                out_free;
    logic                emit_now;

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit_now = (sts.need_rescan && sts.win_one) ||
                      (!sts.need_rescan && sts.hash_less);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wms_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (sts.need_rescan && !sts.win_one) begin
                        state_next = wms_pkg::ST_SCAN;
                    end else if (emit_now && !out_free) begin
                        state_next = wms_pkg::ST_EMIT;
                    end
                end
            end
            wms_pkg::ST_SCAN: begin
                if (sts.scan_last) begin
                    state_next = wms_pkg::ST_DRAIN;
                end
            end
            wms_pkg::ST_DRAIN: begin
                state_next = wms_pkg::ST_EMIT;
            end
            wms_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = wms_pkg::ST_IDLE;
                end
            end
            default: state_next = wms_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            wms_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && emit_now) begin
                    cmd.take_min  = 1'b1;
                    cmd.load_hash = out_free;
                end
            end
            wms_pkg::ST_SCAN: begin
                cmd.scan_issue = 1'b1;
            end
            wms_pkg::ST_DRAIN: begin
                cmd = '0;
            end
            wms_pkg::ST_EMIT: begin
                cmd.load_best = out_free;
            end
            default: cmd = '0;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_hash || cmd.load_best) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wms_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

### rtl/core/wms_datapath.sv
// ----------------------------------------------------------------------------
// wms_datapath: window store, slot pointers and scan comparator
// Keeps the ring window in RAM, tracks fill, write and minimum slots and
// compares one window entry per cycle during a rescan.
// ----------------------------------------------------------------------------
module wms_datapath #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [wms_pkg::WIN_SIZE_W-1:0]   cfg_wr_data,
    input  logic [wms_pkg::HASH_W-1:0]       hash_value,
    input  logic                             start_doc,
    input  wms_pkg::wms_cmd_t                cmd,
    output wms_pkg::wms_sts_t                sts,
    output logic [wms_pkg::HASH_W-1:0]       fingerprint
);

    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int W_W    = $clog2(MAX_WINDOW + 1);
    localparam int CW     = (W_W > wms_pkg::WIN_SIZE_W) ? W_W : wms_pkg::WIN_SIZE_W;

    logic [wms_pkg::WIN_SIZE_W-1:0] win_size_reg;
    logic [W_W-1:0]                 w_eff;
    logic [CW-1:0]                  win_ext;

    logic [SLOT_W-1:0]         write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0]         min_slot_reg, min_slot_next;
    logic [wms_pkg::HASH_W-1:0] min_val_reg, min_val_next;
    logic [W_W-1:0]            fill_reg, fill_next;

    logic [SLOT_W-1:0]          best_slot_reg, best_slot_next;
    logic [wms_pkg::HASH_W-1:0] best_val_reg, best_val_next;
    logic [SLOT_W-1:0]          scan_addr_reg, scan_addr_next;
    logic [W_W-1:0]             scan_cnt_reg, scan_cnt_next;
    logic                       rd_pend_reg, rd_pend_next;
    logic                       rd_ok_reg;
    logic [SLOT_W-1:0]          rd_slot_reg;
    logic [wms_pkg::HASH_W-1:0] fp_reg;

    logic [SLOT_W-1:0]          cur_slot;
    logic [SLOT_W-1:0]          cur_min_slot;
    logic [wms_pkg::HASH_W-1:0] cur_min_val;
    logic [W_W-1:0]             cur_fill;
    logic [SLOT_W-1:0]          last_slot;
    logic [wms_pkg::HASH_W-1:0] rd_data;
    logic [wms_pkg::HASH_W-1:0] cand;

    // clamp the window length into 1..MAX_WINDOW
    assign win_ext = CW'(win_size_reg);
    always_comb begin
        if (win_ext == '0) begin
            w_eff = W_W'(1);
        end else if (win_ext > CW'(MAX_WINDOW)) begin
            w_eff = W_W'(MAX_WINDOW);
        end else begin
            w_eff = win_ext[W_W-1:0];
        end
    end

    // a new document behaves as if the window were cleared before this item
    assign cur_slot     = start_doc ? '0 : write_slot_reg;
    assign cur_min_slot = start_doc ? '0 : min_slot_reg;
    assign cur_min_val  = start_doc ? wms_pkg::HASH_ONES : min_val_reg;
    assign cur_fill     = start_doc ? '0 : fill_reg;
    assign last_slot    = SLOT_W'(w_eff - W_W'(1));

    assign sts.need_rescan = (cur_min_slot == cur_slot);
    assign sts.win_one     = (w_eff == W_W'(1));
    assign sts.hash_less   = (hash_value < cur_min_val);
    assign sts.scan_last   = (scan_cnt_reg == W_W'(1));

    // slots never written since the last clear read as all ones
    assign cand = rd_ok_reg ? rd_data : wms_pkg::HASH_ONES;

    always_comb begin
        write_slot_next = write_slot_reg;
        min_slot_next   = min_slot_reg;
        min_val_next    = min_val_reg;
        fill_next       = fill_reg;
        best_slot_next  = best_slot_reg;
        best_val_next   = best_val_reg;
        scan_addr_next  = scan_addr_reg;
        scan_cnt_next   = scan_cnt_reg;
        rd_pend_next    = cmd.scan_issue;

        if (rd_pend_reg && (cand < best_val_reg)) begin
            best_val_next  = cand;
            best_slot_next = rd_slot_reg;
        end

        if (cmd.accept) begin
            write_slot_next = (W_W'(cur_slot) + W_W'(1) == w_eff) ? '0 : cur_slot + 1'b1;
            fill_next       = (cur_fill < w_eff) ? cur_fill + W_W'(1) : cur_fill;
            min_slot_next   = cur_min_slot;
            min_val_next    = cur_min_val;
            best_val_next   = hash_value;
            best_slot_next  = cur_slot;
            scan_addr_next  = (cur_slot == '0) ? last_slot : cur_slot - 1'b1;
            scan_cnt_next   = w_eff - W_W'(1);
        end

        if (cmd.take_min) begin
            min_slot_next = cur_slot;
            min_val_next  = hash_value;
        end

        if (cmd.scan_issue) begin
            scan_addr_next = (scan_addr_reg == '0) ? last_slot : scan_addr_reg - 1'b1;
            scan_cnt_next  = scan_cnt_reg - W_W'(1);
        end

        if (cmd.load_best) begin
            min_slot_next = best_slot_reg;
            min_val_next  = best_val_reg;
        end

        // a window length write starts over, like a new document
        if (cfg_wr_en) begin
            write_slot_next = '0;
            min_slot_next   = '0;
            min_val_next    = wms_pkg::HASH_ONES;
            fill_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_size_reg   <= wms_pkg::WIN_SIZE_RESET;
            write_slot_reg <= '0;
            min_slot_reg   <= '0;
            min_val_reg    <= wms_pkg::HASH_ONES;
            fill_reg       <= '0;
            rd_pend_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                win_size_reg <= cfg_wr_data;
            end
            write_slot_reg <= write_slot_next;
            min_slot_reg   <= min_slot_next;
            min_val_reg    <= min_val_next;
            fill_reg       <= fill_next;
            rd_pend_reg    <= rd_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_slot_reg <= best_slot_next;
        best_val_reg  <= best_val_next;
        scan_addr_reg <= scan_addr_next;
        scan_cnt_reg  <= scan_cnt_next;
        if (cmd.scan_issue) begin
            rd_slot_reg <= scan_addr_reg;
            rd_ok_reg   <= (W_W'(scan_addr_reg) < fill_reg);
        end
        if (cmd.load_hash) begin
            fp_reg <= hash_value;
        end else if (cmd.load_best) begin
            fp_reg <= best_val_reg;
        end
    end

    wms_ram #(
        .WIDTH (wms_pkg::HASH_W),
        .DEPTH (MAX_WINDOW),
        .AW    (SLOT_W)
    ) u_window (
        .clk     (aclk),
        .wr_en   (cmd.accept),
        .wr_addr (cur_slot),
        .wr_data (hash_value),
        .rd_en   (cmd.scan_issue),
        .rd_addr (scan_addr_reg),
        .rd_data (rd_data)
    );

    assign fingerprint = fp_reg;

endmodule

### rtl/core/winnowing_min_selector.sv
// ----------------------------------------------------------------------------
// winnowing_min_selector: winnowing fingerprint selection over k-gram hashes
// Keeps a ring window of the last W hashes and emits the window minimum as a
// fingerprint whenever it changes.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                          accepted when
//  s_        in         tdata: hash_value, tuser: start  s_tvalid & s_tready
//  m_        out        tdata: fingerprint               m_tvalid & m_tready
//  cfg_wr_   in         window_size (7 bits)             cfg_wr_en
//
//  An item that keeps the held minimum or undercuts it needs no rescan.
//  An item that overwrites the minimum's slot in a window of more than one
//  entry rescans it through one comparator, one RAM read a cycle.
//  Reset (synchronous, aresetn low) loads W = 4 and empties the window; a
//  write to window_size or a start flag empties it again, with no sweep:
//  a fill count marks slots not yet written, which read as all ones.
//  A result waiting for m_tready holds the block after a rescan; otherwise
//  the block goes on taking items until a result meets a full output.
//
module winnowing_min_selector #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    // window length register
    input  logic                           cfg_wr_en,
    input  logic [wms_pkg::WIN_SIZE_W-1:0] cfg_wr_data,

    // hash stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [wms_pkg::HASH_W-1:0]     s_tdata,   // [63:0] hash_value
    input  logic                           s_tuser,   // [0] start_doc

    // fingerprint stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [wms_pkg::HASH_W-1:0]     m_tdata    // [63:0] fingerprint
);

    wms_pkg::wms_cmd_t cmd;
    wms_pkg::wms_sts_t sts;

    // sequence accept, rescan and output hand-off
    wms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // hold the window, the slots and the output register
    wms_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .hash_value  (s_tdata),
        .start_doc   (s_tuser),
        .cmd         (cmd),
        .sts         (sts),
        .fingerprint (m_tdata)
    );

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the winnowing minimum selector
// Drives k-gram hashes with random idling on both streams, predicts every
// fingerprint from a local model of the ring window and compares each
// fingerprint item in order. A directed table comes first, then random
// documents over several window lengths, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                        HASH_W         = wms_pkg::HASH_W;
    localparam int                        WIN_SIZE_W     = wms_pkg::WIN_SIZE_W;
    localparam logic [HASH_W-1:0]         HASH_ONES      = wms_pkg::HASH_ONES;
    localparam logic [WIN_SIZE_W-1:0]     WIN_SIZE_RESET = wms_pkg::WIN_SIZE_RESET;

    localparam int MAX_WINDOW    = 64;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 80;    // outlasts the worst rescan, at W = 64
    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
    localparam int WATCHDOG_MAX  = 3000;  // cycles with no item on either side
    localparam int PHASE_ITEMS   = 45;
    localparam int NUM_PHASES    = 10;
    localparam int HOLD_PHASE    = 3;
    localparam int PAUSE_PHASE   = 5;
    localparam int CFG_RANDOM    = -1;
    localparam int PRINT_MAX     = 50;

    typedef enum int {
        HS_FULL,
        HS_SMALL,
        HS_FALL,
        HS_RISE,
        HS_EDGE
    } hash_style_t;

    typedef struct {
        bit                    do_cfg;
        logic [WIN_SIZE_W-1:0] cfg_val;
        logic [HASH_W-1:0]     hash;
        logic                  start;
        bit                    typed;
        bit                    exp_has;
        logic [HASH_W-1:0]     exp_fp;
    } dir_row_t;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [WIN_SIZE_W-1:0] cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [HASH_W-1:0]     s_tdata;    // [63:0] hash_value
    logic                  s_tuser;    // [0] start_doc
    logic                  m_tvalid;
    logic                  m_tready;
    logic [HASH_W-1:0]     m_tdata;    // [63:0] fingerprint

    // Side-band that travels with each offered item: a typed expectation
    // from the directed table, used instead of the model's when set.
    bit                    item_typed;
    bit                    item_exp_has;
    logic [HASH_W-1:0]     item_exp_fp;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    logic [HASH_W-1:0]     fp_queue [$];     // fingerprints still to come
    int                    err_count   = 0;
    int                    idle_cycles = 0;
    int                    tx_stall_pct = 0;
    int                    rx_stall_pct = 0;
    int                    hold_req     = 0;

    // Local model of the ring window
    logic [HASH_W-1:0]     win_mem [MAX_WINDOW];
    int                    wr_slot;
    int                    mn_slot;
    logic [WIN_SIZE_W-1:0] win_len_reg;

    int cfg_plan [NUM_PHASES] = '{1, 64, 0, 2, 127, 4, 65, 3, CFG_RANDOM, CFG_RANDOM};

    // Directed rows. The window starts at its reset length of four. Rows with
    // typed set carry an expectation that can be read straight off the rules.
    dir_row_t dir_tab [25] = '{
        '{0, 7'd0,   64'h10,                  1'b0, 1, 1, 64'h10},   // first rescan
        '{0, 7'd0,   HASH_ONES,               1'b0, 1, 0, 64'h0},
        '{0, 7'd0,   64'h0,                   1'b0, 1, 1, 64'h0},    // undercut
        '{0, 7'd0,   64'h0,                   1'b0, 1, 0, 64'h0},    // tie, no result
        '{0, 7'd0,   64'hFF,                  1'b0, 1, 0, 64'h0},
        '{0, 7'd0,   64'h5,                   1'b0, 1, 0, 64'h0},
        '{0, 7'd0,   64'h7,                   1'b0, 1, 1, 64'h0},    // rescan finds oldest zero
        '{0, 7'd0,   HASH_ONES,               1'b1, 1, 1, HASH_ONES},// new document
        '{0, 7'd0,   64'h0,                   1'b1, 1, 1, 64'h0},
        '{0, 7'd0,   64'h8000_0000_0000_0000, 1'b0, 0, 0, 64'h0},
        '{0, 7'd0,   64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 0, 0, 64'h0},
        '{0, 7'd0,   64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 0, 0, 64'h0},
        '{0, 7'd0,   64'h5555_5555_5555_5555, 1'b0, 0, 0, 64'h0},
        '{1, 7'd0,   64'h1234,                1'b0, 1, 1, 64'h1234}, // zero acts as one
        '{0, 7'd0,   HASH_ONES,               1'b0, 1, 1, HASH_ONES},
        '{1, 7'd127, 64'h9,                   1'b0, 1, 1, 64'h9},    // saturates to 64
        '{0, 7'd0,   64'hA,                   1'b0, 1, 0, 64'h0},
        '{0, 7'd0,   64'h3,                   1'b0, 1, 1, 64'h3},
        '{1, 7'd1,   HASH_ONES,               1'b0, 1, 1, HASH_ONES},
        '{1, 7'd64,  64'h2,                   1'b0, 1, 1, 64'h2},
        '{0, 7'd0,   64'h1,                   1'b0, 1, 1, 64'h1},
        '{1, 7'd2,   64'h6,                   1'b0, 1, 1, 64'h6},
        '{0, 7'd0,   64'h8,                   1'b0, 1, 0, 64'h0},
        '{0, 7'd0,   64'h9,                   1'b0, 1, 1, 64'h8},    // rescan picks older slot
        '{1, 7'd65,  64'h0,                   1'b0, 1, 1, 64'h0}     // saturates to 64
    };

    // ------------------------------------------------------------------------
    // DUT
    // ------------------------------------------------------------------------
    winnowing_min_selector #(
        .MAX_WINDOW (MAX_WINDOW)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Window model
    // ------------------------------------------------------------------------
    function automatic void clear_window_model();
        for (int i = 0; i < MAX_WINDOW; i++)
            win_mem[i] = HASH_ONES;
        wr_slot = 0;
        mn_slot = 0;
    endfunction

    // Store one hash and work out the fingerprint it selects, if any.
    function automatic void predict_fingerprint(input logic [HASH_W-1:0] hash,
                                                input logic start,
                                                output bit has,
                                                output logic [HASH_W-1:0] fp);
        int w;
        int r;
        int i;
        int best;
        // clamp the register to the usable window length
        w = int'(win_len_reg);
        if (w < 1)
            w = 1;
        if (w > MAX_WINDOW)
            w = MAX_WINDOW;
        if (start)
            clear_window_model();
        r = wr_slot;
        if (r >= w)
            r = 0;
        if (mn_slot >= w)
            mn_slot = 0;
        win_mem[r] = hash;
        has = 1'b0;
        fp  = '0;
        if (mn_slot == r) begin
            // minimum overwritten: scan newest to oldest, strict less keeps
            // the most recent of equal values
            best = r;
            i = (r + w - 1) % w;
            while (i != r) begin
                if (win_mem[i] < win_mem[best])
                    best = i;
                i = (i + w - 1) % w;
            end
            mn_slot = best;
            fp  = win_mem[best];
            has = 1'b1;
        end else if (win_mem[r] < win_mem[mn_slot]) begin
            mn_slot = r;
            fp  = hash;
            has = 1'b1;
        end
        wr_slot = (r + 1) % w;
    endfunction

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [HASH_W-1:0] got,
                                   input logic [HASH_W-1:0] want);
        if (err_count < PRINT_MAX)
            $display("[%0t] mismatch: %s got %h want %h", $realtime, what, got, want);
        err_count++;
    endtask

    // Append one expected fingerprint at the tail of the queue.
    function automatic void enqueue_fp(input logic [HASH_W-1:0] value);
        fp_queue = {fp_queue, value};
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    function automatic logic [HASH_W-1:0] next_hash(input hash_style_t style,
                                                   inout logic [HASH_W-1:0] run);
        case (style)
            HS_SMALL: return HASH_W'($urandom_range(0, 15));
            HS_FALL: begin
                run = run - HASH_W'($urandom_range(0, 3));
                return run;
            end
            HS_RISE: begin
                run = run + HASH_W'($urandom_range(0, 3));
                return run;
            end
            HS_EDGE: begin
                case ($urandom_range(0, 4))
                    0:       return '0;
                    1:       return HASH_ONES;
                    2:       return {1'b1, {(HASH_W-1){1'b0}}};
                    3:       return {1'b0, {(HASH_W-1){1'b1}}};
                    default: return HASH_ONES - HASH_W'($urandom_range(0, 3));
                endcase
            end
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one item and hold it until taken; then maybe idle.
    task automatic send_item(input logic [HASH_W-1:0] hash, input logic start,
                             input bit typed, input bit exp_has,
                             input logic [HASH_W-1:0] exp_fp);
        s_tvalid     <= 1'b1;
        s_tdata      <= hash;
        s_tuser      <= start;
        item_typed   <= typed;
        item_exp_has <= exp_has;
        item_exp_fp  <= exp_fp;
        do @(posedge aclk); while (!s_tready);
        if ($urandom_range(99) < tx_stall_pct) begin
            s_tvalid <= 1'b0;
            repeat (gap_len()) @(posedge aclk);
        end
    endtask

    // Stop offering, wait for every fingerprint, then wait out SETTLE_CYCLES
    // before touching the register.
    task automatic settle_results();
        s_tvalid <= 1'b0;
        while (fp_queue.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(input logic [WIN_SIZE_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        // a write also empties the window
        win_len_reg = value;
        clear_window_model();
    endtask

    // ------------------------------------------------------------------------
    // Monitor: predict on each accepted hash, check each accepted fingerprint,
    // and watch for a stalled run.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        bit                has;
        logic [HASH_W-1:0] fp;
        bit                moved;
        moved = 1'b0;
        if (aresetn && s_tvalid && s_tready) begin
            moved = 1'b1;
            predict_fingerprint(s_tdata, s_tuser, has, fp);
            if (item_typed) begin
                if (has != item_exp_has || (has && fp != item_exp_fp))
                    report_mismatch("table row vs model", fp, item_exp_fp);
                if (item_exp_has)
                    enqueue_fp(item_exp_fp);
            end else if (has) begin
                enqueue_fp(fp);
            end
        end
        if (aresetn && m_tvalid && m_tready) begin
            moved = 1'b1;
            if (fp_queue.size() == 0)
                report_mismatch("unexpected fingerprint", m_tdata, '0);
            else begin
                fp = fp_queue.pop_front();
                if (m_tdata !== fp)
                    report_mismatch("fingerprint", m_tdata, fp);
            end
        end
        if (aresetn) begin
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("[%0t] watchdog: no item moved for %0d cycles",
                         $realtime, WATCHDOG_MAX);
                $display("** winnowing_min_selector: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            if (hold_req != 0) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 0;
            end else if ($urandom_range(99) < rx_stall_pct) begin
                m_tready <= 1'b0;
                repeat (gap_len()) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int                doc_len;
        int                n;
        int                cfg_val;
        logic              start;
        logic [HASH_W-1:0] hash;
        logic [HASH_W-1:0] run;
        hash_style_t       style;

        // hold every input at a known value from time zero
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= 1'b0;
        item_typed   <= 1'b0;
        item_exp_has <= 1'b0;
        item_exp_fp  <= '0;
        win_len_reg  = WIN_SIZE_RESET;
        clear_window_model();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, light idling on both sides
        tx_stall_pct = 15;
        rx_stall_pct = 15;
        foreach (dir_tab[i]) begin
            if (dir_tab[i].do_cfg) begin
                settle_results();
                write_window(dir_tab[i].cfg_val);
            end
            send_item(dir_tab[i].hash, dir_tab[i].start, dir_tab[i].typed,
                      dir_tab[i].exp_has, dir_tab[i].exp_fp);
        end

        // random documents, one window length per phase
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle_results();
            cfg_val = (cfg_plan[ph] == CFG_RANDOM) ? $urandom_range(0, 127) : cfg_plan[ph];
            write_window(WIN_SIZE_W'(cfg_val));

            // first phase runs flat out; the hold phase keeps the sender busy
            // while the receiver holds off, so the block fills and stalls
            if (ph == 0) begin
                tx_stall_pct = 0;
                rx_stall_pct = 0;
            end else if (ph == HOLD_PHASE) begin
                tx_stall_pct = 0;
                rx_stall_pct = 20;
                hold_req     = 1;
            end else begin
                tx_stall_pct = $urandom_range(10, 35);
                rx_stall_pct = $urandom_range(10, 35);
            end

            n = 0;
            while (n < PHASE_ITEMS) begin
                doc_len = $urandom_range(1, 40);
                style   = hash_style_t'($urandom_range(0, 4));
                run     = {$urandom, $urandom};
                for (int k = 0; k < doc_len && n < PHASE_ITEMS; k++) begin
                    // documents usually open with a start flag; stray flags
                    // in the middle act as noise
                    if (k == 0)
                        start = ($urandom_range(99) < 85);
                    else
                        start = ($urandom_range(99) < 2);
                    if ($urandom_range(99) < 10)
                        hash = {$urandom, $urandom};
                    else
                        hash = next_hash(style, run);
                    send_item(hash, start, 1'b0, 1'b0, '0);
                    n++;
                    // pause the sender mid-phase until everything is out
                    if (ph == PAUSE_PHASE && n == PHASE_ITEMS / 2)
                        settle_results();
                end
            end
        end

        settle_results();
        if (err_count == 0)
            $display("** winnowing_min_selector: PASSED **");
        else
            $display("** winnowing_min_selector: FAILED **");
        $finish;
    end

endmodule
